>>> design/length_prefixed_message_ring_defines.svh
// Assertion macros used by the message ring controller.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpmr assertion failed");

// Next-cycle implication.
`define LPMR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpmr assertion failed");

`endif

>>> design/lpmr_pkg.sv
// Types and constants of the length-prefixed message ring.
`default_nettype none

package lpmr_pkg;

   localparam logic [2:0] CMD_PUT_BEGIN = 3'd0;
   localparam logic [2:0] CMD_PUT_BYTE  = 3'd1;
   localparam logic [2:0] CMD_GET       = 3'd2;
   localparam logic [2:0] CMD_PEEK      = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_SEQ   = 2'd3;

   localparam logic [6:0] MAX_MSG_BYTES = 7'd64;
   localparam int         HDR_BYTES     = 4;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic [6:0] msg_length;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [6:0] out_length;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_HDR_WAIT,
      S_RD_DATA,
      S_ZERO
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> design/lpmr_mem.sv
// Byte-wide ring storage: one write port, one read port with registered data.
`default_nettype none

module lpmr_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] ram_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/lpmr_ctrl.sv
// Command sequencer, pointer and space bookkeeping, and result register.
`default_nettype none
`include "length_prefixed_message_ring_defines.svh"

module lpmr_ctrl #(
   parameter int RING_BYTES = 1024,
   parameter int AW         = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lpmr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lpmr_pkg::rsp_type     rsp_data,
   output logic                  wr_en,
   output logic      [AW-1:0]    wr_addr,
   output logic      [7:0]       wr_data,
   output logic                  rd_en,
   output logic      [AW-1:0]    rd_addr,
   input  wire logic [7:0]       rd_data
);

   import lpmr_pkg::*;

   localparam int FW = $clog2(RING_BYTES + 1);
   localparam int CW = $clog2(RING_BYTES / HDR_BYTES + 1);
   localparam int SW = (FW > 7) ? FW + 1 : 8;

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  wp_ff, wp_in;
   logic [AW-1:0]  rp_ff, rp_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [FW-1:0]  free_ff, free_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           open_ff, open_in;
   logic [6:0]     rem_ff, rem_in;
   logic [1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [6:0]     len_ff, len_in;
   logic [6:0]     left_ff, left_in;
   logic           remove_ff, remove_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_next;
   logic           rsp_load;
   logic           slot_free;
   logic [6:0]     hdr_len;
   logic [SW-1:0]  need;
   logic [SW-1:0]  give_back;
   logic [AW-1:0]  ptr_next;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_add_hdr(input logic [AW-1:0] p);
      logic [AW:0] sum;
      sum = {1'b0, p} + (AW + 1)'(HDR_BYTES);
      if (sum >= (AW + 1)'(RING_BYTES)) begin
         sum = sum - (AW + 1)'(RING_BYTES);
      end
      ptr_add_hdr = sum[AW-1:0];
   endfunction

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign hdr_len   = (rd_data > {1'b0, MAX_MSG_BYTES}) ? MAX_MSG_BYTES : rd_data[6:0];
   assign need      = SW'(req_data.msg_length) + SW'(HDR_BYTES);
   assign give_back = SW'(free_ff) + SW'(len_ff) + SW'(HDR_BYTES);
   assign ptr_next  = ptr_inc(ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
         free_ff    <= FW'(RING_BYTES);
         count_ff   <= '0;
         open_ff    <= 1'b0;
         rem_ff     <= '0;
         hdr_cnt_ff <= '0;
         left_ff    <= '0;
         remove_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         free_ff    <= free_in;
         count_ff   <= count_in;
         open_ff    <= open_in;
         rem_ff     <= rem_in;
         hdr_cnt_ff <= hdr_cnt_in;
         left_ff    <= left_in;
         remove_ff  <= remove_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      len_ff <= len_in;
   end

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      ptr_in     = ptr_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      open_in    = open_ff;
      rem_in     = rem_ff;
      hdr_cnt_in = hdr_cnt_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      remove_in  = remove_ff;
      req_stall  = 1'b1;
      rsp_load   = 1'b0;
      rsp_next   = '{status: ST_OK, byte_valid: 1'b0, out_byte: '0, out_length: '0,
                     last: 1'b1};
      wr_en      = 1'b0;
      wr_addr    = wp_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = rp_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = !slot_free;
            if (req_valid && slot_free) begin
               rsp_load = 1'b1;
               unique case (req_data.command) inside
                  CMD_PUT_BEGIN: begin
                     if (open_ff || req_data.msg_length > MAX_MSG_BYTES) begin
                        rsp_next.status = ST_SEQ;
                     end else if (SW'(free_ff) < need) begin
                        rsp_next.status = ST_FULL;
                     end else begin
                        // First header byte carries the length, the rest are zero.
                        wr_en      = 1'b1;
                        wr_data    = {1'b0, req_data.msg_length};
                        wp_in      = ptr_inc(wp_ff);
                        free_in    = FW'(SW'(free_ff) - need);
                        hdr_cnt_in = 2'(HDR_BYTES - 1);
                        state_in   = S_HDR;
                        if (req_data.msg_length == '0) begin
                           count_in = count_ff + CW'(1);
                        end else begin
                           open_in = 1'b1;
                           rem_in  = req_data.msg_length;
                        end
                     end
                  end
                  CMD_PUT_BYTE: begin
                     if (!open_ff) begin
                        rsp_next.status = ST_SEQ;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = req_data.data_byte;
                        wp_in   = ptr_inc(wp_ff);
                        rem_in  = rem_ff - 7'd1;
                        if (rem_ff == 7'd1) begin
                           open_in  = 1'b0;
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  CMD_GET, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_next.status = ST_EMPTY;
                     end else begin
                        // Fetch the header; results follow from the read states.
                        rsp_load  = 1'b0;
                        rd_en     = 1'b1;
                        remove_in = (req_data.command == CMD_GET);
                        state_in  = S_HDR_WAIT;
                     end
                  end
                  CMD_CLEAR: begin
                     wp_in    = '0;
                     rp_in    = '0;
                     free_in  = FW'(RING_BYTES);
                     count_in = '0;
                     open_in  = 1'b0;
                     rem_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HDR: begin
            wr_en      = 1'b1;
            wp_in      = ptr_inc(wp_ff);
            hdr_cnt_in = hdr_cnt_ff - 2'd1;
            if (hdr_cnt_ff == 2'd1) begin
               state_in = S_IDLE;
            end
         end
         S_HDR_WAIT: begin
            len_in  = hdr_len;
            left_in = hdr_len;
            ptr_in  = ptr_add_hdr(rp_ff);
            if (hdr_len == '0) begin
               state_in = S_ZERO;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_add_hdr(rp_ff);
               state_in = S_RD_DATA;
            end
         end
         S_RD_DATA: begin
            if (slot_free) begin
               rsp_load            = 1'b1;
               rsp_next.byte_valid = 1'b1;
               rsp_next.out_byte   = rd_data;
               rsp_next.out_length = len_ff;
               rsp_next.last       = (left_ff == 7'd1);
               left_in             = left_ff - 7'd1;
               if (left_ff == 7'd1) begin
                  state_in = S_IDLE;
                  if (remove_ff) begin
                     rp_in    = ptr_next;
                     free_in  = (give_back > SW'(RING_BYTES)) ? FW'(RING_BYTES)
                                                               : FW'(give_back);
                     count_in = count_ff - CW'(1);
                  end
               end else begin
                  // Overlap the next byte's read with this byte's transaction.
                  rd_en   = 1'b1;
                  rd_addr = ptr_next;
                  ptr_in  = ptr_next;
               end
            end
         end
         S_ZERO: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (remove_ff) begin
                  rp_in    = ptr_ff;
                  free_in  = (give_back > SW'(RING_BYTES)) ? FW'(RING_BYTES)
                                                            : FW'(give_back);
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LPMR_ASSERT_IMP(a_no_rw_overlap, clock, reset, wr_en, !rd_en)
   `LPMR_ASSERT_IMP(a_empty_ring_consistent, clock, reset,
      state_ff == S_IDLE && count_ff == '0 && !open_ff,
      free_ff == FW'(RING_BYTES) && rp_ff == wp_ff)
   `LPMR_ASSERT_IMP(a_read_has_bytes_left, clock, reset, state_ff == S_RD_DATA, left_ff != '0)
   `LPMR_ASSERT_NXT(a_payload_marked_valid, clock, reset,
      rsp_load && state_ff == S_RD_DATA, rsp_data_ff.byte_valid)

endmodule

`default_nettype wire

>>> design/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring.
`default_nettype none

// Byte ring of RING_BYTES entries holding messages as a 4-byte little-endian
// length header plus payload, wrapping byte by byte. Commands arrive one per
// transaction on req_; each gives one result on rsp_ except get and peek of a
// message of length L > 0, which give L results, one per payload byte. Timing
// is set by the single write port and the registered read data of the ring
// memory: put_byte, clear, rejected commands and get/peek of an empty ring are
// answered from the idle state; an accepted put_begin writes its header bytes
// in turn; get and peek read the header and first payload byte, then
// deliver one byte per cycle while rsp_stall is low. A command is taken only
// when the result register is free or being emptied in that cycle. The memory
// is not cleared after reset or by clear; only stored messages are ever read.
module length_prefixed_message_ring #(
   parameter int RING_BYTES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lpmr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lpmr_pkg::rsp_type      rsp_data
);

   import lpmr_pkg::*;

   localparam int AW = $clog2(RING_BYTES);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   lpmr_ctrl #(
      .RING_BYTES (RING_BYTES),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   lpmr_mem #(
      .DEPTH (RING_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
